// File: rtl/hegm_pkg.sv
// Shared types and constants for the envelope gate mixer.
`timescale 1ns / 1ps
package hegm_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_BITS_DEF   = 24;
	localparam int CFG_IDX_BITS    = 3;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_ENV_REL    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_ATT   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_REL   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_THR   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLOSE_THR  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_GATE_EN    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_BYPASS     = 3'd6;

	// Register values after reset
	localparam int ENV_REL_RST   = 8736;
	localparam int GAIN_ATT_RST  = 231413;
	localparam int GAIN_REL_RST  = 4992;
	localparam int OPEN_THR_RST  = 25166;
	localparam int CLOSE_THR_RST = 10066;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENV,
		ST_ENV_UPD,
		ST_GAIN,
		ST_GAIN_UPD,
		ST_MIX,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MODE_GATE,
		MODE_WET,
		MODE_DRY
	} mode_t;

endpackage

// File: rtl/hysteresis_envelope_gate_mixer.sv
// Envelope-driven hysteresis gate blending a dry and a wet sample stream.
//
// Usage:
//   Input channel s_axis_*: one item is a dry and a wet sample of the same instant
//   (tdata, dry in the low bits) with tlast marking the last sample of a block.
//   Output channel m_axis_*: the blended sample, the smoothed gate gain and the
//   gate state, with tlast copied from the input item.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr at the clock edge;
//   write only while the block is idle. Setting gate_enable from 0 to 1 clears the
//   envelope, the gain and the gate.
// Sequencing:
//   All three products go through one multiplier under a small sequencer, one
//   product at a time. A gated item steps through ST_ENV, ST_ENV_UPD (skipped when
//   the sample raises the envelope), ST_GAIN, ST_GAIN_UPD, ST_MIX and ST_DONE, which
//   loads the result register; with bypass or with the gate disabled it goes straight
//   to ST_DONE. The block is ready for the next item in the cycle after the result is loaded.
//   While a result waits in the output register the next item is still taken and
//   processed; it then holds in its last step until the receiver takes the result.
// Reset: registers return to their default values, the state clears and the
//   output register empties.
`timescale 1ns / 1ps
module hysteresis_envelope_gate_mixer
	import hegm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = COEF_BITS_DEF,
	localparam int CFG_W  = (COEF_BITS > SAMPLE_BITS - 1) ? COEF_BITS : SAMPLE_BITS - 1,
	localparam int IN_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W  = ((SAMPLE_BITS + COEF_BITS + 2 + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_addr,
	input  logic [CFG_W-1:0]        cfg_wdata,
	// input items
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_W-1:0]         s_axis_tdata,  // dry_sample, wet_sample, zero pad
	input  logic                    s_axis_tlast,  // block_end
	// result items
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [OUT_W-1:0]        m_axis_tdata,  // mixed_sample, gate_gain, gate_is_open, pad
	output logic                    m_axis_tlast   // last_of_block
);

	localparam int S   = SAMPLE_BITS;
	localparam int C   = COEF_BITS;
	localparam int LW  = S - 1;
	localparam int GW  = C + 1;
	localparam int AW  = C + 1;
	localparam int BW  = (S + 1 > C + 1) ? S + 1 : C + 1;
	localparam int PW  = AW + BW;
	localparam int SW  = BW + 1;
	localparam logic [GW-1:0] GAIN_ONE = {1'b1, {C{1'b0}}};
	localparam logic [LW-1:0] LMAX     = {LW{1'b1}};

	// configuration registers
	logic [C-1:0]  env_rel_q, gain_att_q, gain_rel_q;
	logic [LW-1:0] open_thr_q, close_thr_q;
	logic          gate_en_q, bypass_q;

	// state and working registers
	state_t        state_q, state_d;
	mode_t         mode_q;
	logic [LW-1:0] env_q;
	logic [GW-1:0] gain_q;
	logic          open_q;
	logic [S-1:0]  dry_q, wet_q;
	logic          last_q;
	logic [BW-1:0] diff_mag_q;
	logic          diff_neg_q;
	logic          up_q;
	logic [PW-1:0] prod_q;

	// output register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             out_last_q;

	logic          clr;
	logic          accept;
	logic          load_out;
	logic [S-1:0]  dry_mag;
	logic [LW-1:0] rect;
	logic          rect_gt;
	logic [SW-1:0] step_ceil;
	logic [SW-1:0] step_floor;
	logic [LW-1:0] env_nxt;
	logic          open_nxt;
	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] mul_p;
	logic          gain_rise;
	logic [S:0]    diff;
	logic [S-1:0]  mixed;

	assign clr    = cfg_we && (cfg_addr == REG_GATE_EN) && cfg_wdata[0] && !gate_en_q;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_rel_q   <= C'(ENV_REL_RST);
			gain_att_q  <= C'(GAIN_ATT_RST);
			gain_rel_q  <= C'(GAIN_REL_RST);
			open_thr_q  <= LW'(OPEN_THR_RST);
			close_thr_q <= LW'(CLOSE_THR_RST);
			gate_en_q   <= 1'b0;
			bypass_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ENV_REL:   env_rel_q   <= cfg_wdata[C-1:0];
				REG_GAIN_ATT:  gain_att_q  <= cfg_wdata[C-1:0];
				REG_GAIN_REL:  gain_rel_q  <= cfg_wdata[C-1:0];
				REG_OPEN_THR:  open_thr_q  <= cfg_wdata[LW-1:0];
				REG_CLOSE_THR: close_thr_q <= cfg_wdata[LW-1:0];
				REG_GATE_EN:   gate_en_q   <= cfg_wdata[0];
				REG_BYPASS:    bypass_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// rectified dry sample, most negative value saturates
	assign dry_mag = dry_q[S-1] ? (~dry_q + S'(1)) : dry_q;
	assign rect    = dry_mag[S-1] ? LMAX : dry_mag[LW-1:0];
	assign rect_gt = rect > env_q;

	assign step_floor = prod_q[PW-1:C];
	assign step_ceil  = step_floor + SW'(|prod_q[C-1:0]);

	// new envelope: instant attack in ST_ENV, release step in ST_ENV_UPD
	always_comb begin
		if (state_q == ST_ENV)
			env_nxt = rect;
		else
			env_nxt = env_q - step_ceil[LW-1:0];
		if (open_q)
			open_nxt = !(env_nxt < close_thr_q);
		else
			open_nxt = env_nxt > open_thr_q;
	end

	// shared multiplier operand selection
	assign gain_rise = open_q && (gain_q < GAIN_ONE);
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ENV: begin
				mul_a = {1'b0, env_rel_q};
				mul_b = BW'(env_q - rect);
			end
			ST_GAIN: begin
				if (gain_rise) begin
					mul_a = {1'b0, gain_att_q};
					mul_b = BW'(GAIN_ONE - gain_q);
				end else begin
					mul_a = {1'b0, gain_rel_q};
					mul_b = open_q ? BW'(gain_q - GAIN_ONE) : BW'(gain_q);
				end
			end
			ST_MIX: begin
				mul_a = gain_q;
				mul_b = diff_mag_q;
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign diff = {wet_q[S-1], wet_q} - {dry_q[S-1], dry_q};

	// blend; the true result lies between dry and wet, so wrapping is exact
	always_comb begin
		case (mode_q)
			MODE_DRY: mixed = dry_q;
			MODE_WET: mixed = wet_q;
			default:  mixed = diff_neg_q ? dry_q - step_floor[S-1:0]
			                             : dry_q + step_floor[S-1:0];
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = (bypass_q || !gate_en_q) ? ST_DONE : ST_ENV;
			end
			ST_ENV:      state_d = rect_gt ? ST_GAIN : ST_ENV_UPD;
			ST_ENV_UPD:  state_d = ST_GAIN;
			ST_GAIN:     state_d = ST_GAIN_UPD;
			ST_GAIN_UPD: state_d = ST_MIX;
			ST_MIX:      state_d = ST_DONE;
			ST_DONE: begin
				if (load_out)
					state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// gate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= '0;
			gain_q <= '0;
			open_q <= 1'b0;
		end else if (clr) begin
			env_q  <= '0;
			gain_q <= '0;
			open_q <= 1'b0;
		end else begin
			case (state_q)
				ST_ENV: begin
					if (rect_gt) begin
						env_q  <= env_nxt;
						open_q <= open_nxt;
					end
				end
				ST_ENV_UPD: begin
					env_q  <= env_nxt;
					open_q <= open_nxt;
				end
				ST_GAIN_UPD: begin
					if (up_q)
						gain_q <= gain_q + step_ceil[GW-1:0];
					else
						gain_q <= gain_q - step_ceil[GW-1:0];
				end
				default: ;
			endcase
		end
	end

	// item registers and product
	always_ff @(posedge clk) begin
		if (accept) begin
			dry_q  <= s_axis_tdata[S-1:0];
			wet_q  <= s_axis_tdata[2*S-1:S];
			last_q <= s_axis_tlast;
			if (bypass_q)
				mode_q <= MODE_DRY;
			else if (!gate_en_q)
				mode_q <= MODE_WET;
			else
				mode_q <= MODE_GATE;
		end
		if (state_q == ST_ENV) begin
			diff_neg_q <= diff[S];
			diff_mag_q <= diff[S] ? BW'(-diff) : BW'(diff);
		end
		if (state_q == ST_GAIN)
			up_q <= gain_rise;
		if (state_q == ST_ENV || state_q == ST_GAIN || state_q == ST_MIX)
			prod_q <= mul_p;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= OUT_W'({open_q, gain_q, mixed});
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// checks
	a_gain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= GAIN_ONE)
		else $error("gate gain above unity");

	a_env_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ENV_UPD |-> step_ceil <= SW'(env_q))
		else $error("envelope release step overshoots");

	a_accept_path: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ENV || state_q == ST_DONE))
		else $error("sequencer did not start on accepted item");

	a_open_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ENV && state_q != ST_ENV_UPD && !clr) |=> $stable(open_q))
		else $error("gate flag changed outside envelope update");

	a_gain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_GAIN_UPD && !clr) |=> $stable(gain_q))
		else $error("gain changed outside gain update");

endmodule

// File: tb/tb_hysteresis_envelope_gate_mixer.sv
// Self-checking testbench for the envelope gate mixer against a bit-true predictor.
`timescale 1ns / 1ps
module tb_hysteresis_envelope_gate_mixer;
	import hegm_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam logic [63:0] LEVEL_MAX = 64'h7F_FFFF;
	localparam logic [63:0] GAIN_ONE = 64'h100_0000;
	localparam int PHASE_ITEMS = 180;

	typedef struct packed {
		logic [23:0] dry;
		logic [23:0] wet;
		logic        blk;
	} sample_pair_t;

	typedef struct packed {
		logic [23:0] mixed;
		logic [24:0] gain;
		logic        open;
		logic        last;
	} mix_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [23:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;  // dry_sample, wet_sample
	logic        s_axis_tlast = 1'b0;  // block_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;  // mixed_sample, gate_gain, gate_is_open, pad
	logic        m_axis_tlast;  // last_of_block

	hysteresis_envelope_gate_mixer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// predictor copy of registers and state
	logic [23:0] env_rel, gain_att, gain_rel;
	logic [22:0] open_thr, close_thr;
	logic        gate_on, bypass_on;
	logic [22:0] env_lvl;
	logic [24:0] gain_lvl;
	logic        gate_open;

	sample_pair_t pending_samples_q[$];
	mix_result_t  expected_mix_q[$];
	sample_pair_t item_on_bus;
	bit           bus_busy = 1'b0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	int           errors = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_hysteresis_envelope_gate_mixer failed");
		$finish;
	end

	// floor, or ceil when round_up, of a*m / 2^24
	function automatic logic [63:0] coef_scale(logic [63:0] a, logic [63:0] m, bit round_up);
		logic [63:0] p;
		p = a * m;
		return (p >> 24) + ((round_up && p[23:0] != 0) ? 64'd1 : 64'd0);
	endfunction

	function automatic logic [63:0] glide(logic [63:0] lvl, logic [63:0] tgt, logic [63:0] c);
		if (tgt > lvl)
			return lvl + coef_scale(c, tgt - lvl, 1'b1);
		return lvl - coef_scale(c, lvl - tgt, 1'b1);
	endfunction

	function automatic mix_result_t gate_mix_predict(sample_pair_t it);
		longint      dry, wet, diff;
		logic [63:0] rect, part, mixed;
		mix_result_t r;
		dry = $signed(it.dry);
		wet = $signed(it.wet);
		if (bypass_on) begin
			mixed = dry;
		end else if (!gate_on) begin
			mixed = wet;
		end else begin
			rect = (dry < 0) ? -dry : dry;
			if (rect > LEVEL_MAX)
				rect = LEVEL_MAX;
			if (rect > env_lvl)
				env_lvl = 23'(rect);
			else
				env_lvl = 23'(glide(64'(env_lvl), rect, 64'(env_rel)));
			if (gate_open) begin
				if (env_lvl < close_thr)
					gate_open = 1'b0;
			end else if (env_lvl > open_thr) begin
				gate_open = 1'b1;
			end
			if (gate_open && GAIN_ONE > gain_lvl)
				gain_lvl = 25'(glide(64'(gain_lvl), GAIN_ONE, 64'(gain_att)));
			else
				gain_lvl = 25'(glide(64'(gain_lvl), gate_open ? GAIN_ONE : 64'd0,
					64'(gain_rel)));
			diff = wet - dry;
			part = coef_scale(64'(gain_lvl), (diff < 0) ? -diff : diff, 1'b0);
			mixed = (diff < 0) ? dry - part : dry + part;
		end
		r.mixed = mixed[23:0];
		r.gain = gain_lvl;
		r.open = gate_open;
		r.last = it.blk;
		return r;
	endfunction

	function automatic void check_field(string what, longint want, longint got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endfunction

	// sender: hand over queued items, predict each one as it is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_mix_q.push_back(gate_mix_predict(item_on_bus));
				bus_busy = 1'b0;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_on_bus = pending_samples_q.pop_front();
					bus_busy = 1'b1;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {item_on_bus.wet, item_on_bus.dry};
					s_axis_tlast <= item_on_bus.blk;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		mix_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_mix_q.size() == 0) begin
				$display("%0t ns: unexpected item, expected none, got mixed %0d",
					$time, $signed(m_axis_tdata[23:0]));
				errors++;
			end else begin
				want = expected_mix_q.pop_front();
				check_field("mixed_sample", $signed(want.mixed), $signed(m_axis_tdata[23:0]));
				check_field("gate_gain", want.gain, m_axis_tdata[48:24]);
				check_field("gate_is_open", want.open, m_axis_tdata[49]);
				check_field("last_of_block", want.last, m_axis_tlast);
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENV_REL:   env_rel = val;
			REG_GAIN_ATT:  gain_att = val;
			REG_GAIN_REL:  gain_rel = val;
			REG_OPEN_THR:  open_thr = val[22:0];
			REG_CLOSE_THR: close_thr = val[22:0];
			REG_GATE_EN: begin
				if (val[0] && !gate_on) begin
					env_lvl = '0;
					gain_lvl = '0;
					gate_open = 1'b0;
				end
				gate_on = val[0];
			end
			REG_BYPASS:    bypass_on = val[0];
			default: ;
		endcase
	endtask

	task automatic write_coefs(logic [23:0] e, logic [23:0] a, logic [23:0] r);
		reg_write(REG_ENV_REL, e);
		reg_write(REG_GAIN_ATT, a);
		reg_write(REG_GAIN_REL, r);
	endtask

	task automatic write_thresholds(logic [23:0] o, logic [23:0] c);
		reg_write(REG_OPEN_THR, o);
		reg_write(REG_CLOSE_THR, c);
	endtask

	task automatic push_pair(logic [23:0] dry, logic [23:0] wet, logic blk);
		sample_pair_t it;
		it.dry = dry;
		it.wet = wet;
		it.blk = blk;
		pending_samples_q.push_back(it);
	endtask

	// hold until every item is out and every result is back
	task automatic drain_block;
		while (pending_samples_q.size() != 0 || bus_busy || expected_mix_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// bursts of one loudness each, so the envelope crosses the thresholds both ways
	task automatic queue_program(int count);
		int          i, run_left, amp;
		logic [23:0] dry, wet;
		run_left = 0;
		amp = 0;
		for (i = 0; i < count; i++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(4, 40);
				case ($urandom_range(5))
					0: amp = 0;
					1: amp = 255;
					2: amp = 1 << 14;
					3: amp = 1 << 16;
					4: amp = 1 << 19;
					default: amp = 8388607;
				endcase
			end
			run_left--;
			if ($urandom_range(9) == 0)
				dry = 24'($urandom);
			else
				dry = 24'($urandom_range(0, 2 * amp) - amp);
			if ($urandom_range(1))
				wet = 24'($urandom);
			else
				wet = 24'(dry + ($urandom_range(0, 2000) - 1000));
			if ($urandom_range(31) == 0) begin
				dry = $urandom_range(1) ? 24'h80_0000 : 24'h7F_FFFF;
				wet = ~dry;
			end
			push_pair(dry, wet, run_left == 0 || $urandom_range(15) == 0);
		end
	endtask

	initial begin
		int ph;
		env_rel = 24'(ENV_REL_RST);
		gain_att = 24'(GAIN_ATT_RST);
		gain_rel = 24'(GAIN_REL_RST);
		open_thr = 23'(OPEN_THR_RST);
		close_thr = 23'(CLOSE_THR_RST);
		gate_on = 1'b0;
		bypass_on = 1'b0;
		env_lvl = '0;
		gain_lvl = '0;
		gate_open = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// gate disabled after reset: wet passes
		push_pair(24'd100, -24'sd200, 1'b0);
		push_pair(24'h80_0000, 24'h7F_FFFF, 1'b1);
		drain_block();
		reg_write(REG_BYPASS, 24'd1);
		push_pair(24'h7F_FFFF, 24'h80_0000, 1'b0);
		push_pair(-24'sd1, 24'd1, 1'b1);
		drain_block();
		reg_write(REG_BYPASS, 24'd0);
		reg_write(REG_GATE_EN, 24'd1);
		// equal target and gain first, then full-scale swings and the saturating magnitude
		push_pair(24'd0, 24'd0, 1'b0);
		push_pair(24'h7F_FFFF, 24'h80_0000, 1'b0);
		push_pair(24'h80_0000, 24'h7F_FFFF, 1'b0);
		push_pair(-24'sd1, 24'd1, 1'b0);
		push_pair(24'd1, -24'sd1, 1'b1);
		push_pair(24'd0, 24'h7F_FFFF, 1'b0);
		push_pair(24'd0, 24'h7F_FFFF, 1'b0);
		push_pair(24'd0, 24'h80_0000, 1'b1);
		drain_block();
		// bypass with the gate on leaves the state held
		reg_write(REG_BYPASS, 24'd1);
		push_pair(24'd5000, 24'd77, 1'b0);
		push_pair(24'h80_0000, 24'd0, 1'b1);
		drain_block();
		reg_write(REG_BYPASS, 24'd0);
		// enable written again while on must not clear
		reg_write(REG_GATE_EN, 24'd1);
		push_pair(24'd0, 24'd12345, 1'b0);
		push_pair(24'h40_0000, -24'sd4000, 1'b1);
		drain_block();
		// only bit 0 of enable counts; an unused index does nothing
		reg_write(REG_GATE_EN, 24'd2);
		reg_write(REG_UNUSED, 24'hFF_FFFF);
		push_pair(24'd300, 24'd900, 1'b0);
		drain_block();
		reg_write(REG_GATE_EN, 24'd1);
		push_pair(24'h7F_0000, 24'h00_1000, 1'b1);
		drain_block();

		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 60; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 60; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			case (ph)
				0: write_coefs(24'(ENV_REL_RST), 24'h40_0000, 24'(GAIN_REL_RST));
				1: begin
					write_coefs(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
					write_thresholds(24'd0, 24'd0);
				end
				2: begin
					write_coefs(24'd0, 24'd0, 24'd0);
					write_thresholds(24'hFF_FFFF, 24'hFF_FFFF);
				end
				3: begin
					write_coefs(24'($urandom), 24'($urandom), 24'($urandom));
					// close above open
					write_thresholds(24'($urandom_range(0, 1 << 15)),
						24'($urandom_range(1 << 16, 1 << 20)));
				end
				4: begin
					reg_write(REG_GATE_EN, 24'd0);
					reg_write(REG_GATE_EN, 24'd1);
					write_coefs(24'($urandom), 24'($urandom), 24'($urandom));
					write_thresholds(24'($urandom_range(1 << 12, 1 << 19)),
						24'($urandom_range(0, 1 << 12)));
				end
				5: begin
					reg_write(REG_BYPASS, 24'd1);
					write_coefs(24'($urandom), 24'($urandom), 24'($urandom));
				end
				6: begin
					reg_write(REG_BYPASS, 24'd0);
					reg_write(REG_GATE_EN, 24'd0);
				end
				default: begin
					reg_write(REG_GATE_EN, 24'd1);
					write_coefs(24'($urandom_range(1 << 20, 24'hFF_FFFF)),
						24'($urandom_range(1 << 20, 24'hFF_FFFF)),
						24'($urandom_range(1 << 18, 1 << 22)));
					write_thresholds(24'($urandom_range(1 << 14, 1 << 18)),
						24'($urandom_range(0, 1 << 14)));
				end
			endcase
			queue_program(PHASE_ITEMS);
			drain_block();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_hysteresis_envelope_gate_mixer passed");
		else
			$display("tb_hysteresis_envelope_gate_mixer failed");
		$finish;
	end

endmodule
